// File: design/irrigation_correction_factor_assert.svh
// Assertion macros shared by the irrigation correction factor RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef IRRIGATION_CORRECTION_FACTOR_ASSERT_SVH
`define IRRIGATION_CORRECTION_FACTOR_ASSERT_SVH

`ifndef SYNTH
// Checked at every clock edge while out of reset.
`define ICF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define ICF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ICF_ASSERT(label, prop, msg)
`define ICF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/icf_pkg.sv
// Types and constants of the irrigation correction factor block.
// No dependencies.
package icf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER      = 2'd0,
    CFG_LOWER      = 2'd1,
    CFG_SOIL_EN    = 2'd2,
    CFG_CLIMATE_EN = 2'd3
  } cfg_idx_e;

  // Shared divide-by-constant unit: quotient = (n * RECIP) >> SHIFT, exact over the range.
  // Temperature: n = delta * gain < 2^13, the 16384/1000 = 2^11/125 step folded in.
  // Soil: n = |f * (95 - s)| < 2^23, divided by 45.
  localparam int unsigned DIV_W      = 23;
  localparam int unsigned RCP_W      = 25;
  localparam int unsigned PROD_W     = DIV_W + RCP_W;
  localparam int unsigned RECIP_TEMP = 17179870;  // ceil(2^31 / 125)
  localparam int unsigned SHIFT_TEMP = 20;        // 31 less the 2^11 of the Q14 step
  localparam int unsigned RECIP_SOIL = 11930465;  // ceil(2^29 / 45)
  localparam int unsigned SHIFT_SOIL = 29;

  // Q14 constants.
  localparam int unsigned ONE_Q14        = 16384;
  localparam int unsigned MAX_Q14        = 32768;
  localparam int unsigned HUMID_STEP_Q14 = 3276;
  localparam int unsigned HEAT_GAIN      = 3;  // percent per degree
  localparam int unsigned COLD_GAIN      = 2;  // percent per degree

  localparam int signed TEMP_HOT   = 250;
  localparam int signed TEMP_COLD  = 150;
  localparam int unsigned HUM_WET  = 750;
  localparam int unsigned HUM_DRY  = 300;
  localparam int unsigned SOIL_WET = 50;
  localparam int unsigned SOIL_TOP = 95;

  typedef struct packed {
    logic start;
    logic sel_soil;  // 1: divide by 45, 0: temperature term
  } div_req_t;

endpackage

// File: design/irrigation_correction_factor.sv
// Irrigation watering-time correction factor, top level: sequencer, hysteresis and output.
// Depends on icf_pkg, icf_div and irrigation_correction_factor_assert.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | soil_percent, air_temp_tenths, humidity
//  out     | source    | out_valid_o/out_stall_i | factor, inhibited
//  cfg     | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// When inhibited, the sequencer goes from IDLE straight to FIN, which loads the output
// register; else it runs MUL1, DIV1 and SUM, and with wet soil above 50 % also MUL2 and DIV2,
// before FIN. Each use of the shared reciprocal divider waits in a DIV step for its done pulse.
// The input is stalled while a sample is in work; an output stall holds the sequencer in FIN.
// Reset clears the inhibit flag, the registers to their defaults and the output valid.
`include "irrigation_correction_factor_assert.svh"

module irrigation_correction_factor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [6:0]                     soil_percent_i,
  input  logic signed [11:0]             air_temp_tenths_i,
  input  logic [9:0]                     air_humidity_tenths_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    factor_o,
  output logic                           inhibited_o,
  input  logic                           cfg_we_i,
  input  logic [icf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [icf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import icf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_SUM,
    ST_MUL2,
    ST_DIV2,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [6:0] upper_q, lower_q;
  logic       soil_en_q, climate_en_q;
  logic       inhibit_q;

  logic [6:0]        soil_q;
  logic signed [11:0] temp_q;
  logic [9:0]        hum_q;
  logic              tsub_q;
  logic signed [17:0] f_q;
  logic              neg_q;
  logic [15:0]       res_q;
  logic [DIV_W-1:0]  num_q;
  div_req_t          div_req_q;

  logic        out_valid_q;
  logic [15:0] factor_q;
  logic        out_inh_q;

  logic [DIV_W-1:0] div_quot;
  logic             div_done;

  logic       in_xfer;
  logic [6:0] soil_in;
  logic       inhibit_d;

  // MUL1 terms
  logic signed [12:0] t_ext;
  logic signed [12:0] heat_d, cold_d;
  logic               heat, cold;
  logic [11:0]        tdelta;
  logic [13:0]        tmul;

  // SUM terms
  logic signed [17:0] q_s, hum_adj, f_d;
  logic [15:0]        f_clamp;

  // MUL2 terms
  logic signed [7:0]  kfac;
  logic signed [25:0] sprod;
  logic [25:0]        smag;

  // DIV2 clamp
  logic [15:0]        q_clamp;

  icf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .dividend_i (num_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign soil_in    = soil_en_q ? soil_percent_i : 7'd0;

  always_comb begin
    inhibit_d = inhibit_q;
    if (soil_in >= upper_q) begin
      inhibit_d = 1'b1;
    end else if (soil_in < lower_q) begin
      inhibit_d = 1'b0;
    end
  end

  always_comb begin
    t_ext  = {temp_q[11], temp_q};
    heat_d = t_ext - 13'(TEMP_HOT);
    cold_d = 13'(TEMP_COLD) - t_ext;
    heat   = climate_en_q && (t_ext > 13'(TEMP_HOT));
    cold   = climate_en_q && (t_ext < 13'(TEMP_COLD));
    tdelta = heat ? heat_d[11:0] : cold_d[11:0];
    tmul   = heat ? 14'(tdelta) * 14'(HEAT_GAIN) : 14'(tdelta) * 14'(COLD_GAIN);
  end

  always_comb begin
    q_s     = $signed({1'b0, div_quot[16:0]});
    hum_adj = '0;
    if (climate_en_q && (hum_q > 10'(HUM_WET))) begin
      hum_adj = -$signed(18'(HUMID_STEP_Q14));
    end else if (climate_en_q && (hum_q < 10'(HUM_DRY))) begin
      hum_adj = 18'(HUMID_STEP_Q14);
    end
    f_d = 18'(ONE_Q14) + (tsub_q ? -q_s : q_s) + hum_adj;
    if (f_d < 0) begin
      f_clamp = '0;
    end else if (f_d > 18'(MAX_Q14)) begin
      f_clamp = 16'(MAX_Q14);
    end else begin
      f_clamp = f_d[15:0];
    end
  end

  always_comb begin
    // 95 - s; may go negative when thresholds allow soil above 95
    kfac  = 8'(SOIL_TOP) - $signed({1'b0, soil_q});
    sprod = 26'(f_q) * 26'(kfac);
    smag  = sprod[25] ? 26'(-sprod) : sprod;
    q_clamp = (div_quot > DIV_W'(MAX_Q14)) ? 16'(MAX_Q14) : div_quot[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q      <= 7'(SOIL_TOP);
      lower_q      <= 7'd80;
      soil_en_q    <= 1'b1;
      climate_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UPPER:      upper_q      <= cfg_data_i;
        CFG_LOWER:      lower_q      <= cfg_data_i;
        CFG_SOIL_EN:    soil_en_q    <= cfg_data_i[0];
        CFG_CLIMATE_EN: climate_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inhibit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      div_req_q   <= '0;
      soil_q      <= '0;
      temp_q      <= '0;
      hum_q       <= '0;
      tsub_q      <= 1'b0;
      f_q         <= '0;
      neg_q       <= 1'b0;
      res_q       <= '0;
      num_q       <= '0;
      factor_q    <= '0;
      out_inh_q   <= 1'b0;
    end else begin
      div_req_q.start    <= (state_q == ST_MUL1) || (state_q == ST_MUL2);
      div_req_q.sel_soil <= (state_q == ST_MUL2);
      // FIN reloads the output itself when the waiting result leaves
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            inhibit_q <= inhibit_d;
            soil_q    <= soil_in;
            temp_q    <= air_temp_tenths_i;
            hum_q     <= air_humidity_tenths_i;
            res_q     <= '0;
            state_q   <= inhibit_d ? ST_FIN : ST_MUL1;
          end
        end
        ST_MUL1: begin
          num_q   <= (heat || cold) ? DIV_W'(tmul) : '0;
          tsub_q  <= cold;
          state_q <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_done) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          f_q <= f_d;
          if (soil_q > 7'(SOIL_WET)) begin
            state_q <= ST_MUL2;
          end else begin
            res_q   <= f_clamp;
            state_q <= ST_FIN;
          end
        end
        ST_MUL2: begin
          num_q   <= DIV_W'(smag);
          neg_q   <= sprod[25];
          state_q <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_done) begin
            // truncation toward zero on the magnitude; a negative result clamps to 0
            res_q   <= neg_q ? 16'd0 : q_clamp;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            factor_q    <= res_q;
            out_inh_q   <= inhibit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign inhibited_o = out_inh_q;

  `ICF_ASSERT(a_inh_zero, (out_valid_q && out_inh_q) |-> (factor_q == 16'd0),
              "inhibited result with nonzero factor")
  `ICF_ASSERT(a_factor_max, out_valid_q |-> (factor_q <= 16'(MAX_Q14)),
              "factor above 2.0")
  `ICF_ASSERT(a_done_in_div, div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2),
              "divider done outside a divide step")
  `ICF_ASSERT(a_busy_after_xfer, in_xfer |=> in_stall_o,
              "input not stalled after a transfer")

endmodule

// File: design/icf_div.sv
// Shared divide-by-constant unit: one registered reciprocal multiply per request.
// Depends on icf_pkg and irrigation_correction_factor_assert.svh.
`include "irrigation_correction_factor_assert.svh"

module icf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  icf_pkg::div_req_t         req_i,
  input  logic [icf_pkg::DIV_W-1:0] dividend_i,
  output logic [icf_pkg::DIV_W-1:0] quot_o,
  output logic                      done_o
);
  import icf_pkg::*;

  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic              sel_q;
  logic              done_q;

  always_comb begin
    rcp    = req_i.sel_soil ? RCP_W'(RECIP_SOIL) : RCP_W'(RECIP_TEMP);
    prod_d = PROD_W'(dividend_i) * PROD_W'(rcp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      sel_q  <= 1'b0;
      prod_q <= '0;
    end else begin
      done_q <= req_i.start;
      if (req_i.start) begin
        sel_q  <= req_i.sel_soil;
        prod_q <= prod_d;
      end
    end
  end

  assign quot_o = sel_q ? DIV_W'(prod_q >> SHIFT_SOIL) : DIV_W'(prod_q >> SHIFT_TEMP);
  assign done_o = done_q;

  `ICF_ASSERT(a_done_follows_start, req_i.start |=> done_q, "divider done missing")
  `ICF_ASSERT(a_done_pulse, done_q |=> !done_q, "divider done held")
  `ICF_ASSERT(a_start_not_done, done_q |-> !req_i.start, "divider restarted at done")

endmodule
